// File: sv/rau_pkg.sv
`timescale 1ns / 1ps

package rau_pkg;

  localparam int unsigned FIELD_W = 16;
  localparam int unsigned NUM_W   = 33;
  localparam int unsigned DEN_W   = 32;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_MUL = 2'd1;
  localparam logic [1:0] OP_DIV = 2'd2;
  localparam logic [1:0] OP_CMP = 2'd3;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [FIELD_W-1:0] a_num;
    logic [FIELD_W-1:0] a_den;
    logic [FIELD_W-1:0] b_num;
    logic [FIELD_W-1:0] b_den;
  } rau_in_t;

  typedef struct packed {
    logic [NUM_W-1:0] res_num;
    logic [DEN_W-1:0] res_den;
    logic             is_equal;
    logic             den_zero;
  } rau_out_t;

  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_MUL_DEN,
    CMD_MUL_N1,
    CMD_MUL_N2,
    CMD_ACC,
    CMD_GCD_INIT,
    CMD_GCD_STEP,
    CMD_DIV_INIT,
    CMD_DIV_STEP,
    CMD_OUT
  } dp_cmd_e;

  typedef struct packed {
    logic [1:0] op;
    logic       zero;
    logic       gcd_done;
    logic       div_done;
    logic       out_free;
  } dp_status_t;

endpackage

// File: sv/rau_ctrl.sv
`timescale 1ns / 1ps

module rau_ctrl import rau_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output dp_cmd_e    cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MDEN  = 4'd1;
  localparam logic [3:0] S_MN1   = 4'd2;
  localparam logic [3:0] S_MN2   = 4'd3;
  localparam logic [3:0] S_ACC   = 4'd4;
  localparam logic [3:0] S_CHK   = 4'd5;
  localparam logic [3:0] S_GCD   = 4'd6;
  localparam logic [3:0] S_DINIT = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NOP;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = CMD_LOAD;
          state_d = S_MDEN;
        end
      end
      S_MDEN: begin
        // compare needs no arithmetic
        if (status_i.op == OP_CMP) begin
          state_d = S_OUT;
        end else begin
          cmd_o   = CMD_MUL_DEN;
          state_d = S_MN1;
        end
      end
      S_MN1: begin
        cmd_o   = CMD_MUL_N1;
        state_d = S_MN2;
      end
      S_MN2: begin
        cmd_o   = CMD_MUL_N2;
        state_d = (status_i.op == OP_ADD) ? S_ACC : S_CHK;
      end
      S_ACC: begin
        cmd_o   = CMD_ACC;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (status_i.zero) begin
          state_d = S_OUT;
        end else begin
          cmd_o   = CMD_GCD_INIT;
          state_d = S_GCD;
        end
      end
      S_GCD: begin
        if (status_i.gcd_done) begin
          state_d = S_DINIT;
        end else begin
          cmd_o = CMD_GCD_STEP;
        end
      end
      S_DINIT: begin
        cmd_o   = CMD_DIV_INIT;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (status_i.div_done) begin
          state_d = S_OUT;
        end else begin
          cmd_o = CMD_DIV_STEP;
        end
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o   = CMD_OUT;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: sv/rau_dp.sv
`timescale 1ns / 1ps

module rau_dp import rau_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  rau_in_t    in_data_i,
  input  dp_cmd_e    cmd_i,
  output dp_status_t status_o,
  input  logic       out_stall_i,
  output logic       out_valid_o,
  output rau_out_t   out_data_o
);

  // operands never carry more bits than the input fields
  localparam int unsigned OpW = (OPERAND_WIDTH < FIELD_W) ? OPERAND_WIDTH : FIELD_W;
  localparam int unsigned DW  = 2 * OpW;
  localparam int unsigned NW  = DW + 1;
  localparam int unsigned KW  = $clog2(NW + 1);

  logic [1:0]     op_q;
  logic [OpW-1:0] an_q, ad_q, bn_q, bd_q;
  logic           eq_q;
  logic [DW-1:0]  prod_q;
  logic [NW-1:0]  num_q;
  logic [DW-1:0]  den_q;
  logic [NW-1:0]  u_q, v_q;
  logic [KW-1:0]  k_q;
  logic [NW-1:0]  g_q;
  logic [NW-1:0]  qn_q, qd_q, rn_q, rd_q;
  logic [KW-1:0]  cnt_q;
  logic           out_valid_q;
  rau_out_t       out_q;

  logic [OpW-1:0] mul_a, mul_b;
  logic [DW-1:0]  prod;
  logic [NW:0]    trial_n, trial_d;
  logic           bit_n, bit_d;

  // shared multiplier, operands chosen per step
  always_comb begin
    mul_a = an_q;
    mul_b = bd_q;
    unique case (cmd_i)
      CMD_MUL_DEN: begin
        mul_a = ad_q;
        mul_b = (op_q == OP_DIV) ? bn_q : bd_q;
      end
      CMD_MUL_N1: begin
        mul_a = an_q;
        mul_b = (op_q == OP_MUL) ? bn_q : bd_q;
      end
      CMD_MUL_N2: begin
        mul_a = bn_q;
        mul_b = ad_q;
      end
      default: begin
        mul_a = an_q;
        mul_b = bd_q;
      end
    endcase
  end

  assign prod = {{OpW{1'b0}}, mul_a} * {{OpW{1'b0}}, mul_b};

  // restoring division, numerator and denominator share the divisor
  assign trial_n = {rn_q, qn_q[NW-1]};
  assign trial_d = {rd_q, qd_q[NW-1]};
  assign bit_n   = (trial_n >= {1'b0, g_q});
  assign bit_d   = (trial_d >= {1'b0, g_q});

  assign status_o.op       = op_q;
  assign status_o.zero     = (num_q == '0) || (den_q == '0);
  assign status_o.gcd_done = (u_q == '0);
  assign status_o.div_done = (cnt_q == '0);
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    prod_q <= prod;
    unique case (cmd_i)
      CMD_LOAD: begin
        op_q <= in_data_i.opcode;
        an_q <= in_data_i.a_num[OpW-1:0];
        ad_q <= in_data_i.a_den[OpW-1:0];
        bn_q <= in_data_i.b_num[OpW-1:0];
        bd_q <= in_data_i.b_den[OpW-1:0];
        eq_q <= (in_data_i.a_num[OpW-1:0] == in_data_i.b_num[OpW-1:0]) &&
                (in_data_i.a_den[OpW-1:0] == in_data_i.b_den[OpW-1:0]);
      end
      CMD_MUL_N1: begin
        den_q <= prod_q;
      end
      CMD_MUL_N2: begin
        num_q <= {1'b0, prod_q};
      end
      CMD_ACC: begin
        num_q <= num_q + {1'b0, prod_q};
      end
      CMD_GCD_INIT: begin
        u_q <= num_q;
        v_q <= {1'b0, den_q};
        k_q <= '0;
      end
      CMD_GCD_STEP: begin
        // binary gcd, one move per cycle
        if (!u_q[0] && !v_q[0]) begin
          u_q <= u_q >> 1;
          v_q <= v_q >> 1;
          k_q <= k_q + 1'b1;
        end else if (!u_q[0]) begin
          u_q <= u_q >> 1;
        end else if (!v_q[0]) begin
          v_q <= v_q >> 1;
        end else if (u_q >= v_q) begin
          u_q <= (u_q - v_q) >> 1;
        end else begin
          v_q <= (v_q - u_q) >> 1;
        end
      end
      CMD_DIV_INIT: begin
        g_q   <= v_q << k_q;
        qn_q  <= num_q;
        qd_q  <= {1'b0, den_q};
        rn_q  <= '0;
        rd_q  <= '0;
        cnt_q <= KW'(NW);
      end
      CMD_DIV_STEP: begin
        rn_q  <= bit_n ? NW'(trial_n - {1'b0, g_q}) : trial_n[NW-1:0];
        rd_q  <= bit_d ? NW'(trial_d - {1'b0, g_q}) : trial_d[NW-1:0];
        qn_q  <= {qn_q[NW-2:0], bit_n};
        qd_q  <= {qd_q[NW-2:0], bit_d};
        cnt_q <= cnt_q - 1'b1;
      end
      CMD_OUT: begin
        if (op_q == OP_CMP) begin
          out_q.res_num  <= '0;
          out_q.res_den  <= '0;
          out_q.is_equal <= eq_q;
          out_q.den_zero <= 1'b0;
        end else if (status_o.zero) begin
          // no reduction when either side is zero
          out_q.res_num  <= NUM_W'(num_q);
          out_q.res_den  <= DEN_W'(den_q);
          out_q.is_equal <= 1'b0;
          out_q.den_zero <= (op_q == OP_DIV) && (den_q == '0);
        end else begin
          out_q.res_num  <= NUM_W'(qn_q);
          out_q.res_den  <= DEN_W'(qd_q);
          out_q.is_equal <= 1'b0;
          out_q.den_zero <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i == CMD_OUT) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

endmodule

// File: sv/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
// path to out_valid_o: a compare goes from load straight to the output state; otherwise the
// multiplier steps run (with an accumulate step for add), and a zero numerator or denominator
// skips the reduction; else the binary gcd loop and the bit-serial divider reduce the result
// one item at a time, next beat taken the cycle after the result is loaded; the output
// register lets the next beat in while a result waits
// reset (rst_ni low, asynchronous) returns the controller to idle and drops out_valid_o
module rational_arithmetic_unit import rau_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  rau_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output rau_out_t out_data_o
);

  dp_cmd_e    cmd;
  dp_status_t status;

  rau_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rau_dp #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// File: sv/rau_checker.sv
`timescale 1ns / 1ps

module rau_checker import rau_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input rau_out_t out_data_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // one item in flight: an accepted beat blocks the input next cycle
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while item in flight");

  // a new result only comes from an item that was in flight
  a_res_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without an item");

  // an equal compare result carries no fraction
  a_cmp_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_equal |->
      out_data_o.res_num == '0 && out_data_o.res_den == '0 && !out_data_o.den_zero)
    else $error("compare result has fraction bits");

  // zero-denominator flag only with a zero denominator
  a_dz_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.den_zero |-> out_data_o.res_den == '0)
    else $error("den_zero with nonzero denominator");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// File: bench/tb_rational_arithmetic_unit.sv
`timescale 1ns / 1ps

module tb_rational_arithmetic_unit;
  import rau_pkg::*;

  localparam int unsigned OPERAND_W  = 16;
  localparam int unsigned QUIET_MAX  = 3000;
  localparam int unsigned DRAIN_WAIT = 150;
  localparam int unsigned RAND_BEATS = 300;

  class fraction_scoreboard;
    rau_out_t pending_fractions[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    static function bit [63:0] gcd_of(bit [63:0] x, bit [63:0] y);
      bit [63:0] r;
      while (y != 0) begin
        r = x % y;
        x = y;
        y = r;
      end
      return x;
    endfunction

    static function rau_out_t reduce_fraction(rau_in_t it);
      bit [63:0] msk, an, ad, bn, bd, num, den, g;
      rau_out_t r;
      msk = (64'd1 << OPERAND_W) - 64'd1;
      an  = 64'(it.a_num) & msk;
      ad  = 64'(it.a_den) & msk;
      bn  = 64'(it.b_num) & msk;
      bd  = 64'(it.b_den) & msk;
      num = '0;
      den = '0;
      r   = '0;
      if (it.opcode == OP_CMP) begin
        r.is_equal = (an == bn) && (ad == bd);
      end else begin
        case (it.opcode)
          OP_ADD: begin
            num = an * bd + bn * ad;
            den = ad * bd;
          end
          OP_MUL: begin
            num = an * bn;
            den = ad * bd;
          end
          default: begin
            num = an * bd;
            den = ad * bn;
            r.den_zero = (den == 0);
          end
        endcase
        // zero on either side skips the reduction
        if (num != 0 && den != 0) begin
          g   = gcd_of(num, den);
          num = num / g;
          den = den / g;
        end
        r.res_num = num[NUM_W-1:0];
        r.res_den = den[DEN_W-1:0];
      end
      return r;
    endfunction

    function void note_input(rau_in_t it);
      pending_fractions.push_back(reduce_fraction(it));
    endfunction

    function void check_result(rau_out_t got);
      rau_out_t want;
      if (pending_fractions.size() == 0) begin
        $error("unexpected result beat: res_num=%0d res_den=%0d", got.res_num, got.res_den);
        mismatches++;
        return;
      end
      want = pending_fractions.pop_front();
      if (got.res_num !== want.res_num) begin
        $error("res_num expected %0d actual %0d", want.res_num, got.res_num);
        mismatches++;
      end
      if (got.res_den !== want.res_den) begin
        $error("res_den expected %0d actual %0d", want.res_den, got.res_den);
        mismatches++;
      end
      if (got.is_equal !== want.is_equal) begin
        $error("is_equal expected %0b actual %0b", want.is_equal, got.is_equal);
        mismatches++;
      end
      if (got.den_zero !== want.den_zero) begin
        $error("den_zero expected %0b actual %0b", want.den_zero, got.den_zero);
        mismatches++;
      end
    endfunction
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  rau_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  rau_out_t out_data_o;

  int unsigned src_gap_pct;
  int unsigned sink_stall_pct;
  fraction_scoreboard sb;

  rational_arithmetic_unit #(
    .OPERAND_WIDTH(OPERAND_W)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    out_stall_i    = 1'b0;
    sink_stall_pct = 60;
    src_gap_pct    = 18;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) sb.note_input(in_data_i);
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_MAX) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("FAIL rational_arithmetic_unit");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_fraction(input logic [1:0] op,
                               input logic [FIELD_W-1:0] an, input logic [FIELD_W-1:0] ad,
                               input logic [FIELD_W-1:0] bn, input logic [FIELD_W-1:0] bd);
    rau_in_t it;
    it.opcode = op;
    it.a_num  = an;
    it.a_den  = ad;
    it.b_num  = bn;
    it.b_den  = bd;
    while ($urandom_range(0, 99) < src_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // seven in twenty operands are multiples of a shared factor so the gcd gets real work
  function automatic logic [FIELD_W-1:0] pick_operand(int unsigned factor);
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    if (sel < 9) return FIELD_W'($urandom_range(1, 64) * factor);
    return FIELD_W'($urandom_range(0, 16'hFFFF));
  endfunction

  task automatic send_random_fractions(input int unsigned count);
    logic [1:0] ops[4];
    logic [1:0] op;
    logic [FIELD_W-1:0] an, ad, bn, bd;
    int unsigned factor;
    ops = '{OP_ADD, OP_MUL, OP_DIV, OP_CMP};
    repeat (count) begin
      op     = ops[$urandom_range(0, 3)];
      factor = $urandom_range(1, 512);
      an     = pick_operand(factor);
      ad     = pick_operand(factor);
      bn     = pick_operand(factor);
      bd     = pick_operand(factor);
      // denominators stay nonzero most of the time
      if (ad == 0 && $urandom_range(0, 3) != 0) ad = FIELD_W'($urandom_range(1, 16'hFFFF));
      if (bd == 0 && $urandom_range(0, 3) != 0) bd = FIELD_W'($urandom_range(1, 16'hFFFF));
      if (op == OP_CMP && $urandom_range(0, 1) == 1) begin
        bn = an;
        bd = ad;
        if ($urandom_range(0, 3) == 0) bd = bd ^ FIELD_W'(1 << $urandom_range(0, FIELD_W - 1));
      end
      send_fraction(op, an, ad, bn, bd);
    end
  endtask

  initial begin
    sb         = new();
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_fraction(OP_ADD, 16'd1, 16'd2, 16'd1, 16'd3);
    send_fraction(OP_ADD, 16'd0, 16'd1, 16'd0, 16'd1);
    send_fraction(OP_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_fraction(OP_ADD, 16'hFFFF, 16'hFFFE, 16'hFFFF, 16'hFFFD);
    send_fraction(OP_ADD, 16'd1, 16'hFFFF, 16'd1, 16'hFFFE);
    send_fraction(OP_ADD, 16'd1, 16'd0, 16'd1, 16'd5);
    send_fraction(OP_ADD, 16'd0, 16'd0, 16'd0, 16'd0);
    send_fraction(OP_MUL, 16'hFFFF, 16'd1, 16'hFFFF, 16'd1);
    send_fraction(OP_MUL, 16'd0, 16'd5, 16'd7, 16'd9);
    send_fraction(OP_MUL, 16'd6, 16'd4, 16'd10, 16'd15);
    send_fraction(OP_MUL, 16'd3, 16'd7, 16'd5, 16'd0);
    send_fraction(OP_MUL, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA);
    send_fraction(OP_DIV, 16'd3, 16'd4, 16'd0, 16'd5);
    send_fraction(OP_DIV, 16'd0, 16'd7, 16'd0, 16'd3);
    send_fraction(OP_DIV, 16'd2, 16'd3, 16'd4, 16'd9);
    send_fraction(OP_DIV, 16'hFFFF, 16'd1, 16'd1, 16'hFFFF);
    send_fraction(OP_DIV, 16'd5, 16'd0, 16'd3, 16'd2);
    send_fraction(OP_DIV, 16'd0, 16'd9, 16'd4, 16'd6);
    send_fraction(OP_CMP, 16'd3, 16'd4, 16'd3, 16'd4);
    send_fraction(OP_CMP, 16'd3, 16'd4, 16'd6, 16'd8);
    send_fraction(OP_CMP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_fraction(OP_CMP, 16'd0, 16'd0, 16'd0, 16'd0);
    send_fraction(OP_CMP, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAB);

    send_random_fractions(RAND_BEATS);
    src_gap_pct    = 60;
    sink_stall_pct = 18;
    send_random_fractions(RAND_BEATS);
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    send_random_fractions(RAND_BEATS);
    in_valid_i <= 1'b0;

    while (sb.pending_fractions.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("PASS rational_arithmetic_unit");
    end else begin
      $display("FAIL rational_arithmetic_unit");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/rau_pkg.sv
sv/rau_ctrl.sv
sv/rau_dp.sv
sv/rational_arithmetic_unit.sv
sv/rau_checker.sv
bench/tb_rational_arithmetic_unit.sv
